// File: src/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants for the second-chance replacement ring.
// ----------------------------------------------------------------------------
package scr_pkg;

    // Default ring depth
    localparam int CAPACITY_DEFAULT = 64;

    // Field widths
    localparam int PAGE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = PAGE_W + 1;   // {referenced, page}

    // Operation codes (s_axis_tuser)
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_EVICT  = 1'b1;

    // Status codes (m_axis_tuser)
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for a beat
        ST_EXEC,    // insert, empty or full result, or issue the head read of an evict walk
        ST_CHECK    // head entry read back: rotate it or take it as victim
    } state_t;

endpackage

// File: src/second_chance_replacement_ring.sv
// ----------------------------------------------------------------------------
// second_chance_replacement_ring
// Bounded circular queue of page ids with reference bits; evicts by the
// second-chance (clock) rule.
// ----------------------------------------------------------------------------
// One operation is handled at a time. An insert, and any operation that ends
// in an empty or full status, loads its result from ST_EXEC. An evict reads
// the head entry in ST_EXEC and checks it in ST_CHECK, where each of the k
// referenced head entries is rotated to the tail before the victim is found
// (k <= entry count): each walk step is one synchronous read of the slot
// memory followed by one write-back, so the single-port slot memory sets the
// pace. The next beat is taken once the result is loaded and the block is
// back in ST_IDLE. Reference bits live next to the page ids in the same
// memory; only slots inside the valid window are ever read, so no clearing
// pass is needed after reset and the block is ready right away. A finished
// result sits in an output register, and the next beat is accepted while it
// waits to be taken; the block holds the following result back until that
// register is free.
// ----------------------------------------------------------------------------
module second_chance_replacement_ring
    import scr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PAGE_W-1:0]   s_axis_tdata,   // [15:0] page_id
    input  logic                s_axis_tuser,   // [0] operation

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PAGE_W-1:0]   m_axis_tdata,   // [15:0] victim_id
    output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    // Control state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    // Payload registers
    logic               op_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [PAGE_W-1:0]  victim_reg;
    logic [STATUS_W-1:0] status_reg;

    // Slot memory: {referenced, page}
    logic [ENTRY_W-1:0] slot_mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;

    // Result emission
    logic               emit;
    logic [PAGE_W-1:0]  emit_victim;
    logic [STATUS_W-1:0] emit_status;

    logic               in_beat;
    logic               out_free;
    logic               ring_full;
    logic               ring_empty;
    logic               head_ref;
    logic [SUM_W-1:0]   tail_sum;
    logic [IDX_W-1:0]   tail_idx;
    logic [IDX_W-1:0]   head_inc;

    // Handshake
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = victim_reg;
    assign m_axis_tuser  = status_reg;

    // Ring arithmetic: head + count stays below twice the depth
    assign ring_full  = (count_reg == CNT_W'(CAPACITY));
    assign ring_empty = (count_reg == '0);
    assign tail_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx   = (tail_sum >= SUM_W'(CAPACITY)) ?
                        IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
    assign head_inc   = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign head_ref   = rd_data_reg[ENTRY_W-1];

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_EVICT && !ring_empty)
                begin
                    state_next = ST_CHECK;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (head_ref)
                begin
                    state_next = ST_EXEC;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = tail_idx;
        mem_wr_data = {1'b0, rd_data_reg[PAGE_W-1:0]};
        mem_rd_en   = 1'b0;
        emit        = 1'b0;
        emit_victim = '0;
        emit_status = STATUS_DONE;
        head_next   = head_reg;
        count_next  = count_reg;
        case (state_reg)
            ST_EXEC:
            begin
                if (op_reg == OP_EVICT)
                begin
                    if (ring_empty)
                    begin
                        emit        = out_free;
                        emit_status = STATUS_EMPTY;
                    end
                    else
                    begin
                        mem_rd_en = 1'b1;
                    end
                end
                else if (ring_full)
                begin
                    emit        = out_free;
                    emit_status = STATUS_FULL;
                end
                else if (out_free)
                begin
                    // append at the tail with the reference bit set
                    emit        = 1'b1;
                    mem_wr_en   = 1'b1;
                    mem_wr_data = {1'b1, page_reg};
                    count_next  = count_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (head_ref)
                begin
                    // second chance: move to the tail with the bit cleared
                    mem_wr_en = 1'b1;
                    head_next = head_inc;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    emit_victim = rd_data_reg[PAGE_W-1:0];
                    head_next   = head_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && !m_axis_tready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg   <= s_axis_tuser;
            page_reg <= s_axis_tdata;
        end
        if (emit)
        begin
            victim_reg <= emit_victim;
            status_reg <= emit_status;
        end
    end

    // Slot memory, registered read; read and write never share a cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            slot_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= slot_mem[head_reg];
        end
    end

endmodule

// File: src/scr_checker.sv
// ----------------------------------------------------------------------------
// scr_checker
// Port-level checks for the second-chance replacement ring.
// ----------------------------------------------------------------------------
module scr_checker
    import scr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [PAGE_W-1:0]   m_axis_tdata,
    input  logic [STATUS_W-1:0] m_axis_tuser
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STATUS_DONE ||
                           m_axis_tuser == STATUS_EMPTY ||
                           m_axis_tuser == STATUS_FULL))
        else $error("undefined status code");

    // Empty and full results carry no victim
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_DONE |-> m_axis_tdata == '0)
        else $error("nonzero victim on empty or full status");

    // One operation at a time: busy right after an accepted beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("beat accepted while an operation is in flight");

endmodule

bind second_chance_replacement_ring scr_checker u_scr_checker (.*);
